/* rtl/mhrat_pkg.sv */
// ----------------------------------------------------------------------------
// mhrat_pkg
// Shared types and constants of the mesh hub relay and alert tracker.
// ----------------------------------------------------------------------------
`default_nettype none

package mhrat_pkg;

   // defaults for the top level parameters
   localparam int MAX_DEVICES_DEF  = 32;
   localparam int UNPAIR_BURST_DEF = 3;

   // most results one transaction can produce
   localparam int MAX_RES = 3;

   // input modes
   localparam logic [1:0] MODE_PACKET = 2'd0;
   localparam logic [1:0] MODE_TICK   = 2'd1;
   localparam logic [1:0] MODE_RESET  = 2'd2;

   // message types
   localparam logic [2:0] T_OTHER    = 3'd0;
   localparam logic [2:0] T_ALERT    = 3'd1;
   localparam logic [2:0] T_CLEAR    = 3'd2;
   localparam logic [2:0] T_PAIRREQ  = 3'd3;
   localparam logic [2:0] T_PAIRCONF = 3'd4;
   localparam logic [2:0] T_RELAY    = 3'd5;
   localparam logic [2:0] T_UNPAIR   = 3'd6;

   // result kinds
   localparam logic [1:0] K_FWD    = 2'd0;
   localparam logic [1:0] K_CONF   = 2'd1;
   localparam logic [1:0] K_UNPAIR = 2'd2;
   localparam logic [1:0] K_STATUS = 2'd3;

   // configuration register indexes
   localparam logic [1:0] CSR_OWN_ID    = 2'd0;
   localparam logic [1:0] CSR_BCAST_ID  = 2'd1;
   localparam logic [1:0] CSR_INIT_TTL  = 2'd2;
   localparam logic [1:0] CSR_HOLD_MS   = 2'd3;

   // configuration reset values
   localparam logic [7:0]  OWN_ID_RST   = 8'd0;
   localparam logic [7:0]  BCAST_ID_RST = 8'd255;
   localparam logic [7:0]  INIT_TTL_RST = 8'd3;
   localparam logic [31:0] HOLD_MS_RST  = 32'd20000;

   typedef struct packed {
      logic [7:0]  own_id;
      logic [7:0]  bcast_dest;
      logic [7:0]  initial_ttl;
      logic [31:0] alert_hold_ms;
   } cfg_type;

   typedef struct packed {
      logic [1:0]  mode;
      logic [2:0]  msg_type;
      logic [7:0]  source_id;
      logic [7:0]  dest_id;
      logic [7:0]  hops_left;
      logic        alert_flag;
      logic [31:0] now_ms;
   } item_type;

   typedef struct packed {
      logic [1:0] kind;
      logic [2:0] mtype;
      logic [7:0] src;
      logic [7:0] dst;
      logic [7:0] hops;
      logic       flag;
   } pkt_type;

   typedef struct packed {
      logic        alert_active;
      logic [7:0]  alert_source;
      logic [31:0] onboarded_mask;
      logic [31:0] received_count;
      logic [31:0] relayed_count;
   } status_type;

   // results of one transaction; the third unpair copy reuses pkt1
   typedef struct packed {
      logic [1:0] count;
      pkt_type    pkt0;
      pkt_type    pkt1;
      status_type status;
   } job_type;

   typedef struct packed {
      pkt_type    pkt;
      status_type status;
      logic       last;
   } rsp_type;

endpackage

`default_nettype wire

/* rtl/mhrat_req_if.sv */
// ----------------------------------------------------------------------------
// mhrat_req_if
// Input channel: valid/ready handshake with one item per transaction.
// ----------------------------------------------------------------------------
`default_nettype none

interface mhrat_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  mode;
   logic [2:0]  msg_type;
   logic [7:0]  source_id;
   logic [7:0]  dest_id;
   logic [7:0]  hops_left;
   logic        alert_flag;
   logic [31:0] now_ms;

   modport source (
      output valid, mode, msg_type, source_id, dest_id, hops_left, alert_flag, now_ms,
      input  ready
   );
   modport sink (
      input  valid, mode, msg_type, source_id, dest_id, hops_left, alert_flag, now_ms,
      output ready
   );
endinterface

`default_nettype wire

/* rtl/mhrat_rsp_if.sv */
// ----------------------------------------------------------------------------
// mhrat_rsp_if
// Result channel: valid/ready handshake with one result per transaction.
// ----------------------------------------------------------------------------
`default_nettype none

interface mhrat_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  send_kind;
   logic [2:0]  out_type;
   logic [7:0]  out_source;
   logic [7:0]  out_dest;
   logic [7:0]  out_hops;
   logic        out_alert_flag;
   logic        alert_active;
   logic [7:0]  alert_source;
   logic [31:0] onboarded_mask;
   logic [31:0] received_count;
   logic [31:0] relayed_count;
   logic        last;

   modport source (
      output valid, send_kind, out_type, out_source, out_dest, out_hops, out_alert_flag,
             alert_active, alert_source, onboarded_mask, received_count, relayed_count, last,
      input  ready
   );
   modport sink (
      input  valid, send_kind, out_type, out_source, out_dest, out_hops, out_alert_flag,
             alert_active, alert_source, onboarded_mask, received_count, relayed_count, last,
      output ready
   );
endinterface

`default_nettype wire

/* rtl/mesh_hub_relay_and_alert_tracker_core.sv */
// ----------------------------------------------------------------------------
// mesh_hub_relay_and_alert_tracker_core
// Mesh hub relay, pairing and alert tracker.
//
// req_chan carries one item per transaction: a received packet, a time tick
// or a reset-connections command. rsp_chan returns one to three results per
// item (confirm, forward, unpair broadcasts or a status-only result), the
// final one flagged by last. Each result carries the tracker state after
// the whole item.
// csr_we/csr_index/csr_wdata write own_id, the unpair destination,
// initial_ttl and alert_hold_ms; write only while no item is in flight.
// Each accepted item is stored in the result list register, and its results
// then move one by one through the output register to rsp_chan. An item
// holds the result list register until its last result moves on, so
// single-result items are taken every cycle while rsp_chan is ready; the
// output register sends one result per cycle while rsp_chan is ready.
// When rsp_chan stalls the output register holds, the result list fills and
// req_chan.ready drops until the list can drain.
// reset (synchronous) clears the tracker state, empties both registers and
// loads the configuration defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module mesh_hub_relay_and_alert_tracker_core
   import mhrat_pkg::*;
#(
   parameter int MAX_DEVICES  = MAX_DEVICES_DEF,
   parameter int UNPAIR_BURST = UNPAIR_BURST_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   mhrat_req_if.sink        req_chan,
   mhrat_rsp_if.source      rsp_chan,
   input  wire logic        csr_we,
   input  wire logic [1:0]  csr_index,
   input  wire logic [31:0] csr_wdata
);

   cfg_type  cfg_ff;
   item_type item;
   job_type  job;
   rsp_type  out_data;
   logic     in_ready;
   logic     accept;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.own_id        <= OWN_ID_RST;
         cfg_ff.bcast_dest    <= BCAST_ID_RST;
         cfg_ff.initial_ttl   <= INIT_TTL_RST;
         cfg_ff.alert_hold_ms <= HOLD_MS_RST;
      end else if (csr_we) begin
         case (csr_index)
            CSR_OWN_ID:   cfg_ff.own_id        <= csr_wdata[7:0];
            CSR_BCAST_ID: cfg_ff.bcast_dest    <= csr_wdata[7:0];
            CSR_INIT_TTL: cfg_ff.initial_ttl   <= csr_wdata[7:0];
            CSR_HOLD_MS:  cfg_ff.alert_hold_ms <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   assign item = '{mode: req_chan.mode, msg_type: req_chan.msg_type,
                   source_id: req_chan.source_id, dest_id: req_chan.dest_id,
                   hops_left: req_chan.hops_left, alert_flag: req_chan.alert_flag,
                   now_ms: req_chan.now_ms};

   assign accept         = req_chan.valid && in_ready;
   assign req_chan.ready = in_ready;

   mhrat_proc #(
      .MAX_DEVICES  (MAX_DEVICES),
      .UNPAIR_BURST (UNPAIR_BURST)
   ) u_proc (
      .clock  (clock),
      .reset  (reset),
      .accept (accept),
      .item   (item),
      .cfg    (cfg_ff),
      .job    (job)
   );

   mhrat_emit u_emit (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .job       (job),
      .in_ready  (in_ready),
      .out_valid (rsp_chan.valid),
      .out_ready (rsp_chan.ready),
      .out_data  (out_data)
   );

   assign rsp_chan.send_kind      = out_data.pkt.kind;
   assign rsp_chan.out_type       = out_data.pkt.mtype;
   assign rsp_chan.out_source     = out_data.pkt.src;
   assign rsp_chan.out_dest       = out_data.pkt.dst;
   assign rsp_chan.out_hops       = out_data.pkt.hops;
   assign rsp_chan.out_alert_flag = out_data.pkt.flag;
   assign rsp_chan.alert_active   = out_data.status.alert_active;
   assign rsp_chan.alert_source   = out_data.status.alert_source;
   assign rsp_chan.onboarded_mask = out_data.status.onboarded_mask;
   assign rsp_chan.received_count = out_data.status.received_count;
   assign rsp_chan.relayed_count  = out_data.status.relayed_count;
   assign rsp_chan.last           = out_data.last;

endmodule

`default_nettype wire

/* rtl/mhrat_proc.sv */
// ----------------------------------------------------------------------------
// mhrat_proc
// Tracker state and the per-item decode that builds the result list.
// ----------------------------------------------------------------------------
`default_nettype none

module mhrat_proc
   import mhrat_pkg::*;
#(
   parameter int MAX_DEVICES  = MAX_DEVICES_DEF,
   parameter int UNPAIR_BURST = UNPAIR_BURST_DEF
) (
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     accept,
   input  wire item_type item,
   input  wire cfg_type  cfg,
   output job_type       job
);

   localparam int         BurstN   = (UNPAIR_BURST > MAX_RES) ? MAX_RES : UNPAIR_BURST;
   localparam logic [1:0] BurstCnt = 2'(BurstN);

   // device slot of every source id, built at elaboration
   function automatic logic [2047:0] slot_table();
      logic [2047:0] t;
      t = '0;
      for (int i = 0; i < 256; i++) begin
         t[i*8 +: 8] = 8'(i % MAX_DEVICES);
      end
      return t;
   endfunction

   localparam logic [2047:0] SlotTable = slot_table();

   logic        alert_on_ff, alert_on_in;
   logic [7:0]  alert_origin_ff, alert_origin_in;
   logic [31:0] alert_time_ff, alert_time_in;
   logic [31:0] paired_bits_ff, paired_bits_in;
   logic [31:0] rx_total_ff, rx_total_in;
   logic [31:0] fwd_total_ff, fwd_total_in;

   logic        do_fwd;
   logic [7:0]  dev_idx;
   logic [31:0] age;
   pkt_type     conf_pkt, fwd_pkt, unpair_pkt, status_pkt;

   assign dev_idx = SlotTable[{item.source_id, 3'b000} +: 8];
   assign age     = item.now_ms - alert_time_ff;
   assign do_fwd  = (item.msg_type >= T_ALERT) && (item.msg_type <= T_RELAY) &&
                    (item.hops_left != 8'd0) && (item.dest_id != cfg.own_id);

   assign conf_pkt   = '{kind: K_CONF, mtype: T_PAIRCONF, src: cfg.own_id,
                         dst: item.source_id, hops: cfg.initial_ttl, flag: 1'b0};
   assign fwd_pkt    = '{kind: K_FWD, mtype: item.msg_type, src: item.source_id,
                         dst: item.dest_id, hops: item.hops_left - 8'd1,
                         flag: item.alert_flag};
   assign unpair_pkt = '{kind: K_UNPAIR, mtype: T_UNPAIR, src: cfg.own_id,
                         dst: cfg.bcast_dest, hops: cfg.initial_ttl, flag: 1'b0};
   assign status_pkt = '{kind: K_STATUS, mtype: T_OTHER, src: 8'd0, dst: 8'd0,
                         hops: 8'd0, flag: 1'b0};

   always_comb begin
      alert_on_in     = alert_on_ff;
      alert_origin_in = alert_origin_ff;
      alert_time_in   = alert_time_ff;
      paired_bits_in  = paired_bits_ff;
      rx_total_in     = rx_total_ff;
      fwd_total_in    = fwd_total_ff;
      job.count       = 2'd1;
      job.pkt0        = status_pkt;
      job.pkt1        = status_pkt;
      case (item.mode)
         MODE_PACKET: begin
            rx_total_in = rx_total_ff + 32'd1;
            case (item.msg_type)
               T_ALERT: begin
                  alert_time_in   = item.now_ms;
                  alert_on_in     = item.alert_flag;
                  alert_origin_in = item.source_id;
               end
               T_CLEAR: begin
                  alert_on_in = 1'b0;
               end
               T_PAIRREQ: begin
                  if (dev_idx[7:5] == 3'd0) begin
                     paired_bits_in = paired_bits_ff | (32'd1 << dev_idx[4:0]);
                  end
               end
               default: begin
               end
            endcase
            if (do_fwd) begin
               fwd_total_in = fwd_total_ff + 32'd1;
            end
            if (item.msg_type == T_PAIRREQ) begin
               job.pkt0  = conf_pkt;
               job.pkt1  = fwd_pkt;
               job.count = do_fwd ? 2'd2 : 2'd1;
            end else if (do_fwd) begin
               job.pkt0 = fwd_pkt;
            end
         end
         MODE_TICK: begin
            if (alert_on_ff && (age > cfg.alert_hold_ms)) begin
               alert_on_in = 1'b0;
            end
         end
         MODE_RESET: begin
            paired_bits_in = 32'd0;
            job.pkt0       = unpair_pkt;
            job.pkt1       = unpair_pkt;
            job.count      = BurstCnt;
         end
         default: begin
         end
      endcase
      job.status = '{alert_active: alert_on_in, alert_source: alert_origin_in,
                     onboarded_mask: paired_bits_in, received_count: rx_total_in,
                     relayed_count: fwd_total_in};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         alert_on_ff     <= 1'b0;
         alert_origin_ff <= 8'd0;
         alert_time_ff   <= 32'd0;
         paired_bits_ff  <= 32'd0;
         rx_total_ff     <= 32'd0;
         fwd_total_ff    <= 32'd0;
      end else if (accept) begin
         alert_on_ff     <= alert_on_in;
         alert_origin_ff <= alert_origin_in;
         alert_time_ff   <= alert_time_in;
         paired_bits_ff  <= paired_bits_in;
         rx_total_ff     <= rx_total_in;
         fwd_total_ff    <= fwd_total_in;
      end
   end

endmodule

`default_nettype wire

/* rtl/mhrat_emit.sv */
// ----------------------------------------------------------------------------
// mhrat_emit
// Holds the result list of one item and sends it one result per cycle,
// while the output is not stalled, through an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module mhrat_emit
   import mhrat_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    accept,
   input  wire job_type job,
   output logic         in_ready,
   output logic         out_valid,
   input  wire logic    out_ready,
   output rsp_type      out_data
);

   job_type    job_ff;
   logic       job_valid_ff;
   logic [1:0] idx_ff;
   logic       out_valid_ff;
   rsp_type    out_ff;

   logic load;
   logic take;
   logic at_last;
   logic job_done;

   assign load     = !out_valid_ff || out_ready;
   assign take     = load && job_valid_ff;
   assign at_last  = (idx_ff == (job_ff.count - 2'd1));
   assign job_done = take && at_last;
   assign in_ready = !job_valid_ff || job_done;

   always_ff @(posedge clock) begin
      if (reset) begin
         job_valid_ff <= 1'b0;
         idx_ff       <= 2'd0;
      end else if (accept) begin
         job_valid_ff <= 1'b1;
         idx_ff       <= 2'd0;
      end else if (job_done) begin
         job_valid_ff <= 1'b0;
         idx_ff       <= 2'd0;
      end else if (take) begin
         idx_ff <= idx_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         job_ff <= job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (load) begin
         out_valid_ff <= job_valid_ff;
      end
   end

   // later copies of an unpair burst repeat the second slot
   always_ff @(posedge clock) begin
      if (take) begin
         out_ff.pkt    <= (idx_ff == 2'd0) ? job_ff.pkt0 : job_ff.pkt1;
         out_ff.status <= job_ff.status;
         out_ff.last   <= at_last;
      end
   end

   assign out_valid = out_valid_ff;
   assign out_data  = out_ff;

endmodule

`default_nettype wire

/* tb/sv/mhrat_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mhrat_checker
// Watches the request, result and register ports of the mesh hub core,
// keeps its own copy of the tracker state and configuration, works out the
// results of every accepted transaction and compares each result field by
// field, in order, against them.
// ----------------------------------------------------------------------------

module mhrat_checker
   import mhrat_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   mhrat_req_if        req_mon,
   mhrat_rsp_if        rsp_mon,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_wdata,
   output int          mismatch_count,
   output int          results_owed
);

   localparam int PRINT_CAP = 60;

   cfg_type     hub_cfg;
   status_type  hub_state;
   logic [31:0] alert_stamp;
   rsp_type     expected_results[$];

   task automatic report_mismatch(input string msg);
      if (mismatch_count < PRINT_CAP) begin
         $display("[%0t] mismatch: %s", $time, msg);
      end
      mismatch_count++;
   endtask

   task automatic check_field(input string name, input logic [31:0] got,
                              input logic [31:0] want);
      if (got !== want) begin
         report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
      end
   endtask

   function automatic pkt_type make_pkt(logic [1:0] kind, logic [2:0] mtype,
                                        logic [7:0] src, logic [7:0] dst,
                                        logic [7:0] hops, logic flag);
      pkt_type p;
      p.kind  = kind;
      p.mtype = mtype;
      p.src   = src;
      p.dst   = dst;
      p.hops  = hops;
      p.flag  = flag;
      return p;
   endfunction

   // advance the shadow state by one item and queue the results it causes
   task automatic predict_hub_results(input item_type it);
      pkt_type     pkts[MAX_RES];
      rsp_type     r;
      int          n;
      int          burst;
      int unsigned slot;
      n = 0;
      case (it.mode)
         MODE_PACKET: begin
            hub_state.received_count = hub_state.received_count + 32'd1;
            if (it.msg_type == T_ALERT) begin
               alert_stamp            = it.now_ms;
               hub_state.alert_active = it.alert_flag;
               hub_state.alert_source = it.source_id;
            end else if (it.msg_type == T_CLEAR) begin
               hub_state.alert_active = 1'b0;
            end else if (it.msg_type == T_PAIRREQ) begin
               slot = it.source_id % MAX_DEVICES_DEF;
               if (slot < 32) begin
                  hub_state.onboarded_mask[slot] = 1'b1;
               end
               pkts[n] = make_pkt(K_CONF, T_PAIRCONF, hub_cfg.own_id, it.source_id,
                                  hub_cfg.initial_ttl, 1'b0);
               n++;
            end
            if (it.msg_type >= T_ALERT && it.msg_type <= T_RELAY && it.hops_left != 8'd0
                && it.dest_id != hub_cfg.own_id) begin
               pkts[n] = make_pkt(K_FWD, it.msg_type, it.source_id, it.dest_id,
                                  it.hops_left - 8'd1, it.alert_flag);
               n++;
               hub_state.relayed_count = hub_state.relayed_count + 32'd1;
            end
         end
         MODE_TICK: begin
            // wrapping age of the alert
            if (hub_state.alert_active && (it.now_ms - alert_stamp) > hub_cfg.alert_hold_ms)
            begin
               hub_state.alert_active = 1'b0;
            end
         end
         MODE_RESET: begin
            burst = (UNPAIR_BURST_DEF > MAX_RES) ? MAX_RES : UNPAIR_BURST_DEF;
            hub_state.onboarded_mask = '0;
            for (int i = 0; i < burst; i++) begin
               pkts[n] = make_pkt(K_UNPAIR, T_UNPAIR, hub_cfg.own_id, hub_cfg.bcast_dest,
                                  hub_cfg.initial_ttl, 1'b0);
               n++;
            end
         end
         default: ;
      endcase
      if (n == 0) begin
         pkts[0] = make_pkt(K_STATUS, T_OTHER, 8'd0, 8'd0, 8'd0, 1'b0);
         n = 1;
      end
      for (int k = 0; k < n; k++) begin
         r.pkt    = pkts[k];
         r.status = hub_state;
         r.last   = (k == n - 1);
         expected_results.push_back(r);
      end
   endtask

   always @(posedge clock) begin
      rsp_type want;
      item_type seen;
      if (reset) begin
         hub_cfg.own_id        = OWN_ID_RST;
         hub_cfg.bcast_dest    = BCAST_ID_RST;
         hub_cfg.initial_ttl   = INIT_TTL_RST;
         hub_cfg.alert_hold_ms = HOLD_MS_RST;
         hub_state             = '0;
         alert_stamp           = '0;
         mismatch_count        = 0;
         expected_results.delete();
         results_owed <= 0;
      end else begin
         if (csr_we === 1'b1) begin
            case (csr_index)
               CSR_OWN_ID:   hub_cfg.own_id        = csr_wdata[7:0];
               CSR_BCAST_ID: hub_cfg.bcast_dest    = csr_wdata[7:0];
               CSR_INIT_TTL: hub_cfg.initial_ttl   = csr_wdata[7:0];
               CSR_HOLD_MS:  hub_cfg.alert_hold_ms = csr_wdata;
               default: ;
            endcase
         end
         if (rsp_mon.valid === 1'b1 && rsp_mon.ready === 1'b1) begin
            if (expected_results.size() == 0) begin
               report_mismatch("result transaction with nothing expected");
            end else begin
               want = expected_results.pop_front();
               check_field("send_kind", 32'(rsp_mon.send_kind), 32'(want.pkt.kind));
               check_field("out_type", 32'(rsp_mon.out_type), 32'(want.pkt.mtype));
               check_field("out_source", 32'(rsp_mon.out_source), 32'(want.pkt.src));
               check_field("out_dest", 32'(rsp_mon.out_dest), 32'(want.pkt.dst));
               check_field("out_hops", 32'(rsp_mon.out_hops), 32'(want.pkt.hops));
               check_field("out_alert_flag", 32'(rsp_mon.out_alert_flag),
                           32'(want.pkt.flag));
               check_field("alert_active", 32'(rsp_mon.alert_active),
                           32'(want.status.alert_active));
               check_field("alert_source", 32'(rsp_mon.alert_source),
                           32'(want.status.alert_source));
               check_field("onboarded_mask", rsp_mon.onboarded_mask,
                           want.status.onboarded_mask);
               check_field("received_count", rsp_mon.received_count,
                           want.status.received_count);
               check_field("relayed_count", rsp_mon.relayed_count,
                           want.status.relayed_count);
               check_field("last", 32'(rsp_mon.last), 32'(want.last));
            end
         end
         if (req_mon.valid === 1'b1 && req_mon.ready === 1'b1) begin
            seen.mode       = req_mon.mode;
            seen.msg_type   = req_mon.msg_type;
            seen.source_id  = req_mon.source_id;
            seen.dest_id    = req_mon.dest_id;
            seen.hops_left  = req_mon.hops_left;
            seen.alert_flag = req_mon.alert_flag;
            seen.now_ms     = req_mon.now_ms;
            predict_hub_results(seen);
         end
         results_owed <= expected_results.size();
      end
   end

endmodule

/* tb/sv/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives the mesh hub core with a directed set of packets, ticks and
// connection resets, then random traffic under several register settings,
// with random idling on both channels and one long result stall. The
// checker beside the core predicts and compares every result.
// ----------------------------------------------------------------------------

module tb_top;
   import mhrat_pkg::*;

   localparam logic [1:0] MODE_IGNORED     = 2'd3;
   localparam logic [2:0] T_UNUSED         = 3'd7;
   localparam int         LONG_HOLD_CYCLES = 90;
   localparam int         CYCLE_LIMIT      = 300000;

   logic        clock         = 1'b0;
   logic        reset         = 1'b1;
   logic        csr_we        = 1'b0;
   logic [1:0]  csr_index     = CSR_OWN_ID;
   logic [31:0] csr_wdata     = '0;
   logic        rsp_ready     = 1'b0;
   logic        tail_phase    = 1'b0;
   logic        long_hold_req = 1'b0;
   logic        hold_taken    = 1'b0;
   int          stall_pct     = 0;
   int          stall_left    = 0;
   int          hold_left     = 0;
   int          gap_pct       = 0;
   int          cycle_count   = 0;
   int          mismatch_count;
   int          results_owed;
   logic [31:0] sim_ms        = '0;
   cfg_type     hub_cfg;

   mhrat_req_if req_bus ();
   mhrat_rsp_if rsp_bus ();

   assign rsp_bus.ready = rsp_ready;

   mesh_hub_relay_and_alert_tracker_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_bus),
      .rsp_chan  (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   mhrat_checker hub_check (
      .clock          (clock),
      .reset          (reset),
      .req_mon        (req_bus),
      .rsp_mon        (rsp_bus),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .mismatch_count (mismatch_count),
      .results_owed   (results_owed)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   // result side: random stall bursts, plus one long hold-off
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready  <= 1'b0;
         stall_left <= 0;
         hold_left  <= 0;
      end else if (long_hold_req && !hold_taken) begin
         hold_taken <= 1'b1;
         hold_left  <= LONG_HOLD_CYCLES - 1;
         rsp_ready  <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else if (stall_left != 0) begin
         stall_left <= stall_left - 1;
         rsp_ready  <= 1'b0;
      end else if (!tail_phase && $urandom_range(0, 99) < stall_pct) begin
         stall_left <= $urandom_range(0, 12);
         rsp_ready  <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   function automatic item_type pkt_item(logic [2:0] mtype, logic [7:0] src,
                                         logic [7:0] dst, logic [7:0] hops,
                                         logic flag, logic [31:0] now);
      item_type it;
      it.mode       = MODE_PACKET;
      it.msg_type   = mtype;
      it.source_id  = src;
      it.dest_id    = dst;
      it.hops_left  = hops;
      it.alert_flag = flag;
      it.now_ms     = now;
      return it;
   endfunction

   function automatic item_type ctl_item(logic [1:0] mode, logic [31:0] now);
      item_type it;
      it        = '0;
      it.mode   = mode;
      it.now_ms = now;
      return it;
   endfunction

   // mostly well-formed traffic, biased toward alerts, pairing and own-id hits
   function automatic item_type random_item();
      item_type it;
      int       roll;
      roll          = $urandom_range(0, 99);
      it.mode       = MODE_PACKET;
      it.msg_type   = 3'($urandom_range(0, 7));
      it.source_id  = 8'($urandom);
      it.dest_id    = 8'($urandom);
      it.hops_left  = 8'($urandom);
      it.alert_flag = 1'($urandom);
      if (roll < 15) begin
         it.mode = MODE_TICK;
      end else if (roll < 19) begin
         it.mode = MODE_RESET;
      end else if (roll < 22) begin
         it.mode = MODE_IGNORED;
      end else if (roll < 40) begin
         it.msg_type   = T_ALERT;
         it.alert_flag = ($urandom_range(0, 3) != 0);
      end else if (roll < 50) begin
         it.msg_type = T_PAIRREQ;
      end
      roll = $urandom_range(0, 99);
      if (roll < 20) begin
         it.dest_id = hub_cfg.own_id;
      end else if (roll < 35) begin
         it.hops_left = 8'd0;
      end else if (roll < 45) begin
         it.hops_left = 8'd1;
      end
      if ($urandom_range(0, 9) == 0) begin
         it.now_ms = $urandom;
      end else begin
         sim_ms    = sim_ms + 32'($urandom_range(0, 12000));
         it.now_ms = sim_ms;
      end
      return it;
   endfunction

   task automatic send_item(input item_type it);
      int gap;
      if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
         gap = $urandom_range(1, 13);
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid      <= 1'b1;
      req_bus.mode       <= it.mode;
      req_bus.msg_type   <= it.msg_type;
      req_bus.source_id  <= it.source_id;
      req_bus.dest_id    <= it.dest_id;
      req_bus.hops_left  <= it.hops_left;
      req_bus.alert_flag <= it.alert_flag;
      req_bus.now_ms     <= it.now_ms;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
   endtask

   // idle the request side and let every owed result drain
   task automatic close_phase();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (results_owed != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic program_config(input cfg_type c);
      csr_we    <= 1'b1;
      csr_index <= CSR_OWN_ID;
      csr_wdata <= {24'd0, c.own_id};
      @(posedge clock);
      csr_index <= CSR_BCAST_ID;
      csr_wdata <= {24'd0, c.bcast_dest};
      @(posedge clock);
      csr_index <= CSR_INIT_TTL;
      csr_wdata <= {24'd0, c.initial_ttl};
      @(posedge clock);
      csr_index <= CSR_HOLD_MS;
      csr_wdata <= c.alert_hold_ms;
      @(posedge clock);
      csr_we  <= 1'b0;
      hub_cfg = c;
   endtask

   initial begin
      cfg_type c;
      req_bus.valid      <= 1'b0;
      req_bus.mode       <= MODE_PACKET;
      req_bus.msg_type   <= T_OTHER;
      req_bus.source_id  <= '0;
      req_bus.dest_id    <= '0;
      req_bus.hops_left  <= '0;
      req_bus.alert_flag <= 1'b0;
      req_bus.now_ms     <= '0;
      hub_cfg.own_id        = OWN_ID_RST;
      hub_cfg.bcast_dest    = BCAST_ID_RST;
      hub_cfg.initial_ttl   = INIT_TTL_RST;
      hub_cfg.alert_hold_ms = HOLD_MS_RST;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed, reset configuration, no idling
      send_item(pkt_item(T_OTHER, 8'h12, 8'h34, 8'd5, 1'b1, 32'd0));
      send_item(pkt_item(T_PAIRREQ, 8'd0, 8'd9, 8'd255, 1'b0, 32'd10));
      send_item(pkt_item(T_PAIRREQ, 8'd255, 8'd9, 8'd0, 1'b0, 32'd20));
      send_item(pkt_item(T_PAIRREQ, 8'd37, 8'd0, 8'd4, 1'b1, 32'd30));
      send_item(pkt_item(T_ALERT, 8'd7, 8'd200, 8'd1, 1'b1, 32'd1000));
      // exactly the hold time is not yet expired
      send_item(ctl_item(MODE_TICK, 32'd21000));
      send_item(ctl_item(MODE_TICK, 32'd21001));
      send_item(ctl_item(MODE_TICK, 32'd50000));
      // lowered alert still takes source and time
      send_item(pkt_item(T_ALERT, 8'd200, 8'd0, 8'd3, 1'b0, 32'd60000));
      send_item(pkt_item(T_ALERT, 8'd99, 8'd255, 8'd2, 1'b1, 32'hFFFF_FF00));
      send_item(ctl_item(MODE_TICK, 32'h0000_0100));
      send_item(pkt_item(T_ALERT, 8'hAA, 8'h55, 8'd0, 1'b1, 32'hFFFF_FFFF));
      send_item(ctl_item(MODE_TICK, 32'h0000_4E20));
      send_item(pkt_item(T_ALERT, 8'd1, 8'd2, 8'd3, 1'b1, 32'd100));
      send_item(pkt_item(T_CLEAR, 8'd3, 8'd5, 8'd1, 1'b0, 32'd200));
      send_item(pkt_item(T_PAIRCONF, 8'd4, 8'd6, 8'd1, 1'b1, 32'd300));
      send_item(pkt_item(T_RELAY, 8'hFF, 8'hFE, 8'hFF, 1'b1, 32'd400));
      send_item(pkt_item(T_RELAY, 8'd1, 8'd2, 8'd0, 1'b1, 32'd500));
      send_item(pkt_item(T_RELAY, 8'd9, 8'd0, 8'd9, 1'b0, 32'd550));
      send_item(pkt_item(T_UNPAIR, 8'd8, 8'd7, 8'd5, 1'b1, 32'd600));
      send_item(pkt_item(T_UNUSED, 8'h5A, 8'hA5, 8'd5, 1'b1, 32'd700));
      send_item(ctl_item(MODE_RESET, 32'd800));
      send_item(ctl_item(MODE_IGNORED, 32'hFFFF_FFFF));
      close_phase();

      // extremes, back-to-back requests, long result hold-off
      c.own_id        = 8'hFF;
      c.bcast_dest    = 8'h00;
      c.initial_ttl   = 8'h00;
      c.alert_hold_ms = 32'd0;
      program_config(c);
      gap_pct = 0;
      stall_pct     <= 20;
      long_hold_req <= 1'b1;
      repeat (110) send_item(random_item());
      close_phase();

      c.own_id        = 8'h00;
      c.bcast_dest    = 8'hFF;
      c.initial_ttl   = 8'hFF;
      c.alert_hold_ms = 32'hFFFF_FFFF;
      program_config(c);
      gap_pct = 25;
      stall_pct <= 25;
      repeat (110) send_item(random_item());
      close_phase();

      c.own_id        = 8'($urandom);
      c.bcast_dest    = 8'($urandom);
      c.initial_ttl   = 8'($urandom);
      c.alert_hold_ms = 32'($urandom_range(0, 30000));
      program_config(c);
      gap_pct = 50;
      stall_pct <= 50;
      repeat (100) send_item(random_item());
      close_phase();

      // tail without idling on either side
      c.own_id        = 8'($urandom);
      c.bcast_dest    = 8'($urandom);
      c.initial_ttl   = 8'($urandom);
      c.alert_hold_ms = 32'($urandom_range(0, 20000));
      program_config(c);
      gap_pct = 0;
      tail_phase <= 1'b1;
      repeat (80) send_item(random_item());
      close_phase();
      repeat (6) @(posedge clock);

      if (mismatch_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
